### src/ldnal_pkg.sv
// Package with the types shared by the divisor search block and its divider.
package ldnal_pkg;

    // Status that the shared divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/largest_divisor_not_above_limit_top.sv
// Top level of the block that finds the largest divisor of a value not above a limit.
//
// Usage: an input transfer (in_valid high, in_stall low) carries value and limit.
// One result transfer (out_valid high, out_stall low) follows for every input,
// carrying divisor and error. A limit of zero gives error 1 and divisor 0; a value
// of zero gives the limit; a value not above the limit gives the value itself.
// Otherwise candidates i = 1, 2, 3 ... up to the square root of the value are each
// tried in turn with the shared restoring divider. The search stops at the first
// cofactor value / i that is not above the limit; failing that, the result is the
// largest candidate i that divides the value and is not above the limit.
// in_stall is high from the accepted transfer until the result has been moved to
// the output register; one finished result may wait there while the next item is
// taken in. When the receiver stalls, the output holds its result unchanged and a
// second finished result waits inside the block. Reset empties the output register
// and returns the sequencer to idle; nothing else needs clearing.
module largest_divisor_not_above_limit_top #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OPERAND_BITS-1:0] value,
    input  logic [OPERAND_BITS-1:0] limit,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OPERAND_BITS-1:0] divisor,
    output logic                    error
);
    import ldnal_pkg::*;

    localparam int W = OPERAND_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]   state_reg;
    logic [2:0]   state_next;
    logic [W-1:0] v_reg;
    logic [W-1:0] lim_reg;
    logic [W-1:0] i_reg;
    logic [W-1:0] i_next;
    logic [W:0]   sq_reg;
    logic [W:0]   sq_next;
    logic [W-1:0] best_reg;
    logic [W-1:0] best_next;
    logic [W-1:0] res_div_reg;
    logic [W-1:0] res_div_next;
    logic         res_err_reg;
    logic         res_err_next;
    logic [W-1:0] divisor_reg;
    logic         error_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_xfer;
    logic         out_load;
    logic         div_start;
    logic [W-1:0] quot;
    logic [W-1:0] rem;
    div_stat_t    div_stat;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign div_start = (state_reg == S_START);

    // Shared divider that tests one candidate at a time.
    ldnal_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (v_reg),
        .divisor   (i_reg),
        .quotient  (quot),
        .remainder (rem),
        .stat      (div_stat)
    );

    // Sequencer for the special cases and the candidate search.
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        best_next    = best_reg;
        res_div_next = res_div_reg;
        res_err_next = res_err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    i_next       = W'(1);
                    sq_next      = (W+1)'(1);
                    best_next    = W'(1);
                    res_err_next = 1'b0;
                    if (limit == '0)
                    begin
                        res_div_next = '0;
                        res_err_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (value == '0)
                    begin
                        res_div_next = limit;
                        state_next   = S_DONE;
                    end
                    else if (value <= limit)
                    begin
                        res_div_next = value;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (rem == '0 && quot <= lim_reg)
                    begin
                        // The cofactor is at least every smaller candidate, so it wins.
                        res_div_next = quot;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        if (rem == '0 && i_reg <= lim_reg)
                        begin
                            best_next = i_reg;
                        end
                        i_next  = i_reg + 1'b1;
                        sq_next = sq_reg + {i_reg, 1'b1};
                        if (sq_next > {1'b0, v_reg})
                        begin
                            res_div_next = best_next;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed result transfers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operands, search registers and results.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            v_reg   <= value;
            lim_reg <= limit;
        end
        i_reg       <= i_next;
        sq_reg      <= sq_next;
        best_reg    <= best_next;
        res_div_reg <= res_div_next;
        res_err_reg <= res_err_next;
        if (out_load)
        begin
            divisor_reg <= res_div_next;
            error_reg   <= res_err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign error     = error_reg;

`ifndef SYNTH
    // An error result always carries a zero divisor.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> divisor == '0)
        else $error("error result with nonzero divisor");
    // A good result is never zero.
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> divisor != '0)
        else $error("zero divisor without error");
    // The divider runs only while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy || div_stat.done |-> state_reg == S_WAIT)
        else $error("divider active outside the wait state");
    // An accepted transfer always leaves the idle state.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after an input transfer");
`endif

endmodule

### src/ldnal_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ldnal_div #(
    parameter int W = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [W-1:0]              dividend,
    input  logic [W-1:0]              divisor,
    output logic [W-1:0]              quotient,
    output logic [W-1:0]              remainder,
    output ldnal_pkg::div_stat_t      stat
);
    import ldnal_pkg::*;

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  q_next;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  r_next;
    logic [W-1:0]  d_reg;
    logic [W:0]    trial;

    // One trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (!trial[W])
        begin
            r_next = trial[W-1:0];
            q_next = {q_reg[W-2:0], 1'b1};
        end
        else
        begin
            r_next = {r_reg[W-2:0], q_reg[W-1]};
            q_next = {q_reg[W-2:0], 1'b0};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTH
    // The completion pulse follows the last step of a running division.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");
    // A division never runs longer than one step per quotient bit.
    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == CW'(W - 1) && !start |=> !busy_reg && done_reg)
        else $error("divider did not finish after its last step");
`endif

endmodule

### verif/tb_largest_divisor_not_above_limit_top.sv
// Self-checking testbench for the largest divisor not above a limit block.
module tb_largest_divisor_not_above_limit_top;

    localparam int W = 31;
    localparam logic [W-1:0] OPERAND_MAX = {W{1'b1}};
    localparam logic ERR_NONE = 1'b0;
    localparam logic ERR_ZERO_LIMIT = 1'b1;

    // Candidate budgets keep the data-dependent search short for most items.
    localparam int unsigned SHALLOW_CAP = 64;
    localparam int unsigned DEEP_CAP = 1100;
    localparam int RANDOM_ITEMS = 580;
    localparam int DEEP_EVERY = 116;
    localparam int QUIET_TAIL = 60;
    localparam int DRAIN_CYCLES = 100;
    localparam int WATCHDOG_CYCLES = 4 * (W + 2) * (DEEP_CAP + 2);
    localparam int DIRECTED_ROWS = 20;

    // One expected result together with the operands that caused it.
    typedef struct packed {
        logic [W-1:0] value;
        logic [W-1:0] limit;
        logic [W-1:0] divisor;
        logic         error;
    } divisor_expect_t;

    // A directed row; typed rows carry their result, the others go to the predictor.
    typedef struct packed {
        bit           typed;
        logic [W-1:0] value;
        logic [W-1:0] limit;
        logic [W-1:0] divisor;
        logic         error;
    } operand_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [W-1:0] value = '0;
    logic [W-1:0] limit = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] divisor;
    logic         error;

    divisor_expect_t expected_divisors[$];
    int              mismatches = 0;
    int              quiet_cycles = 0;
    int              stall_left = 0;
    bit              no_idling = 1'b0;

    operand_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 31'd0, 31'd0, 31'd0, ERR_ZERO_LIMIT},
        '{1'b1, OPERAND_MAX, 31'd0, 31'd0, ERR_ZERO_LIMIT},
        '{1'b1, 31'd0, OPERAND_MAX, OPERAND_MAX, ERR_NONE},
        '{1'b1, OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, ERR_NONE},
        '{1'b1, 31'd0, 31'd1, 31'd1, ERR_NONE},
        '{1'b1, 31'd1, 31'd1, 31'd1, ERR_NONE},
        '{1'b1, 31'd1, OPERAND_MAX, 31'd1, ERR_NONE},
        '{1'b1, 31'h5555_5555, 31'h5555_5555, 31'h5555_5555, ERR_NONE},
        '{1'b1, 31'h2AAA_AAAA, OPERAND_MAX, 31'h2AAA_AAAA, ERR_NONE},
        '{1'b0, 31'h7FFF_FFFE, 31'h3FFF_FFFF, 31'd0, ERR_NONE},
        '{1'b0, 31'h4000_0000, 31'h2000_0001, 31'd0, ERR_NONE},
        '{1'b0, 31'h2AAA_AAAA, 31'h1555_5555, 31'd0, ERR_NONE},
        '{1'b0, 31'd1000, 31'd1, 31'd0, ERR_NONE},
        '{1'b0, 31'd997, 31'd996, 31'd0, ERR_NONE},
        '{1'b0, 31'd12, 31'd5, 31'd0, ERR_NONE},
        '{1'b0, 31'd36, 31'd6, 31'd0, ERR_NONE},
        '{1'b0, 31'd100, 31'd9, 31'd0, ERR_NONE},
        '{1'b0, 31'd64, 31'd63, 31'd0, ERR_NONE},
        '{1'b0, 31'd3, 31'd2, 31'd0, ERR_NONE},
        '{1'b0, 31'd12288, 31'd4095, 31'd0, ERR_NONE}
    };

    largest_divisor_not_above_limit_top #(
        .OPERAND_BITS(W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .limit(limit),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .divisor(divisor),
        .error(error)
    );

    // Free-running clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the expected result and how many candidates the block tries on the way.
    // The first cofactor not above the limit is the answer; failing that, the
    // largest small divisor not above the limit is.
    function automatic divisor_expect_t largest_divisor(input logic [W-1:0] v,
                                                        input logic [W-1:0] l,
                                                        output int unsigned cands);
        divisor_expect_t  res;
        longint unsigned  i;
        longint unsigned  cofactor;
        res = '{value: v, limit: l, divisor: '0, error: ERR_NONE};
        cands = 0;
        if (l == 0)
        begin
            res.error = ERR_ZERO_LIMIT;
        end
        else if (v == 0)
        begin
            res.divisor = l;
        end
        else if (v <= l)
        begin
            res.divisor = v;
        end
        else
        begin
            res.divisor = 1;
            for (i = 1; i * i <= v; i++)
            begin
                cands = int'(i);
                if (v % i == 0)
                begin
                    cofactor = v / i;
                    if (cofactor <= l)
                    begin
                        res.divisor = cofactor[W-1:0];
                        break;
                    end
                    if (i <= l && i > res.divisor)
                        res.divisor = i[W-1:0];
                end
            end
        end
        return res;
    endfunction

    // Draws one random operand pair whose search stays within the candidate budget.
    task automatic draw_operands(input bit deep, output divisor_expect_t item);
        logic [31:0]  v;
        logic [31:0]  l;
        logic [31:0]  k;
        logic [31:0]  m;
        int unsigned  sel;
        int unsigned  cands;
        int unsigned  cap;
        int unsigned  w;
        cap = deep ? DEEP_CAP : SHALLOW_CAP;
        cands = cap + 1;
        while (cands > cap)
        begin
            sel = $urandom_range(0, 99);
            if (deep)
            begin
                // Wider value with a limit below it, so the search may run to the root.
                w = $urandom_range(14, 20);
                v = ($urandom & (32'hFFFF_FFFF >> (32 - w))) | 32'd2;
                l = $urandom_range(1, v - 1);
            end
            else if (sel < 35)
            begin
                // Small value, limit of any width.
                w = $urandom_range(1, 12);
                v = $urandom & (32'hFFFF_FFFF >> (32 - w));
                w = $urandom_range(1, 31);
                l = $urandom & (32'hFFFF_FFFF >> (32 - w));
            end
            else if (sel < 70)
            begin
                // Value with a small known factor k, limit at or just above its cofactor.
                k = $urandom_range(1, 40);
                m = $urandom_range(1, 32'h7FFF_FFFF / k);
                v = k * m;
                l = m + ($urandom % (m / 4 + 1));
                if (l > OPERAND_MAX)
                    l = OPERAND_MAX;
            end
            else if (sel < 85)
            begin
                // Value not above the limit.
                v = $urandom & OPERAND_MAX;
                l = v | ($urandom & OPERAND_MAX);
            end
            else if (sel < 92)
            begin
                // Zero limit.
                v = $urandom & OPERAND_MAX;
                l = 0;
            end
            else
            begin
                // Zero or unit value against any limit.
                v = $urandom_range(0, 1);
                l = $urandom & OPERAND_MAX;
            end
            item = largest_divisor(v[W-1:0], l[W-1:0], cands);
        end
    endtask

    // Offers one operand pair and records its expectation once the transfer is taken.
    task automatic send_operands(input divisor_expect_t item);
        int unsigned gap;
        if (!no_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        value = item.value;
        limit = item.limit;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_divisors.push_back(item);
        @(negedge clk);
    endtask

    // Receiver stalls in random bursts, and never in the quiet tail.
    always @(negedge clk)
    begin
        if (stall_left > 0 && !no_idling)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (!no_idling && $urandom_range(0, 4) == 0)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(1, 5) - 1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Compares every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_divisors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: divisor %0d error %0d", divisor, error);
            end
            else
            begin
                if (divisor !== expected_divisors[0].divisor
                    || error !== expected_divisors[0].error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch for value %0d limit %0d: expected %0d/%0d, got %0d/%0d",
                                 expected_divisors[0].value, expected_divisors[0].limit,
                                 expected_divisors[0].divisor, expected_divisors[0].error,
                                 divisor, error);
                end
                void'(expected_divisors.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Reset, directed table, random operands, then drain.
    initial
    begin
        divisor_expect_t item;
        int unsigned     cands;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].typed)
                item = '{value: directed_rows[r].value, limit: directed_rows[r].limit,
                         divisor: directed_rows[r].divisor, error: directed_rows[r].error};
            else
                item = largest_divisor(directed_rows[r].value, directed_rows[r].limit, cands);
            send_operands(item);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idling = (n >= RANDOM_ITEMS - QUIET_TAIL);
            draw_operands(n % DEEP_EVERY == DEEP_EVERY - 1, item);
            send_operands(item);
        end
        in_valid = 1'b0;

        while (expected_divisors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
src/ldnal_pkg.sv
src/ldnal_div.sv
src/largest_divisor_not_above_limit_top.sv
verif/tb_largest_divisor_not_above_limit_top.sv
